FILE: rtl/tkp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_pkg
// Types and constants shared by the terminal keyboard/printer interface.
// ----------------------------------------------------------------------------
package tkp_pkg;

    localparam int AC_W    = 18;
    localparam int KEY_W   = 8;
    localparam int CHAR_W  = 7;
    localparam int DELAY_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_KBD  = 2'd0,
        CMD_PRT  = 2'd1,
        CMD_KEY  = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KBD_UPPER = 2'd0,
        CFG_PRT_UPPER = 2'd1,
        CFG_DELAY     = 2'd2,
        CFG_NONE      = 2'd3
    } cfg_idx_t;

    // Pulse bit positions.
    localparam int PULSE_SKIP  = 0;
    localparam int PULSE_CLEAR = 1;
    localparam int PULSE_LOAD  = 2;

    localparam logic [CHAR_W-1:0]  LOWER_A    = 7'o141;
    localparam logic [CHAR_W-1:0]  LOWER_Z    = 7'o172;
    localparam logic [CHAR_W-1:0]  CASE_DIFF  = 7'o040;
    localparam logic [CHAR_W-1:0]  PRINT_LO   = 7'o007;
    localparam logic [CHAR_W-1:0]  PRINT_HI   = 7'o137;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]       command;
        logic [2:0]       pulse;
        logic [AC_W-1:0]  ac;
        logic [KEY_W-1:0] key_code;
    } in_word_t;

    typedef struct packed {
        logic [AC_W-1:0]   ac_out;
        logic              skip;
        logic              print_valid;
        logic [CHAR_W-1:0] print_char;
        logic              kbd_flag_out;
        logic              prt_flag_out;
    } out_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] ac_or;
        logic             skip;
        logic             flag;
    } kbd_status_t;

    typedef struct packed {
        logic              skip;
        logic              print_valid;
        logic [CHAR_W-1:0] print_char;
        logic              flag;
    } prt_status_t;

endpackage

FILE: rtl/tkp_keyboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_keyboard
// Keyboard half: receive buffer, done flag, skip test and read into AC.
// ----------------------------------------------------------------------------
module tkp_keyboard
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tkp_pkg::in_word_t   word,
    input  logic                upper_case,
    output tkp_pkg::kbd_status_t status
);

    logic [tkp_pkg::KEY_W-1:0]  kbd_buffer_reg, kbd_buffer_next;
    logic                       kbd_flag_reg, kbd_flag_next;
    logic [tkp_pkg::CHAR_W-1:0] key_char;

    always_comb
    begin
        kbd_buffer_next = kbd_buffer_reg;
        kbd_flag_next   = kbd_flag_reg;
        status          = '0;
        key_char        = word.key_code[tkp_pkg::CHAR_W-1:0];
        if (upper_case && key_char >= tkp_pkg::LOWER_A && key_char <= tkp_pkg::LOWER_Z)
        begin
            key_char = key_char - tkp_pkg::CASE_DIFF;
        end
        case (word.command)
            tkp_pkg::CMD_KBD:
            begin
                status.skip = word.pulse[tkp_pkg::PULSE_SKIP] & kbd_flag_reg;
                if (word.pulse[tkp_pkg::PULSE_CLEAR])
                begin
                    kbd_flag_next = 1'b0;
                    status.ac_or  = kbd_buffer_reg;
                end
            end
            tkp_pkg::CMD_KEY:
            begin
                // Bit 0200 is always set in a stored key.
                kbd_buffer_next = {1'b1, key_char};
                kbd_flag_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
        status.flag = kbd_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbd_buffer_reg <= '0;
            kbd_flag_reg   <= 1'b0;
        end
        else if (accept)
        begin
            kbd_buffer_reg <= kbd_buffer_next;
            kbd_flag_reg   <= kbd_flag_next;
        end
    end

endmodule

FILE: rtl/tkp_printer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_printer
// Printer half: output buffer, print countdown, done flag and skip test.
// ----------------------------------------------------------------------------
module tkp_printer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  tkp_pkg::in_word_t           word,
    input  logic                        upper_case,
    input  logic [tkp_pkg::DELAY_W-1:0] delay,
    output tkp_pkg::prt_status_t        status
);

    // Only the low seven bits of the loaded byte are ever printed.
    logic [tkp_pkg::CHAR_W-1:0]  prt_buffer_reg, prt_buffer_next;
    logic                        prt_flag_reg, prt_flag_next;
    logic [tkp_pkg::DELAY_W-1:0] busy_count_reg, busy_count_next;

    always_comb
    begin
        prt_buffer_next = prt_buffer_reg;
        prt_flag_next   = prt_flag_reg;
        busy_count_next = busy_count_reg;
        status          = '0;
        case (word.command)
            tkp_pkg::CMD_PRT:
            begin
                status.skip = word.pulse[tkp_pkg::PULSE_SKIP] & prt_flag_reg;
                if (word.pulse[tkp_pkg::PULSE_CLEAR])
                begin
                    prt_flag_next = 1'b0;
                end
                if (word.pulse[tkp_pkg::PULSE_LOAD])
                begin
                    prt_buffer_next = word.ac[tkp_pkg::CHAR_W-1:0];
                    if (busy_count_reg == '0)
                    begin
                        // A delay of zero behaves as one tick.
                        busy_count_next = (delay == '0) ? tkp_pkg::DELAY_W'(1) : delay;
                    end
                end
            end
            tkp_pkg::CMD_TICK:
            begin
                if (busy_count_reg != '0)
                begin
                    busy_count_next = busy_count_reg - tkp_pkg::DELAY_W'(1);
                    if (busy_count_reg == tkp_pkg::DELAY_W'(1))
                    begin
                        prt_flag_next = 1'b1;
                        if (!upper_case || (prt_buffer_reg >= tkp_pkg::PRINT_LO &&
                                            prt_buffer_reg <= tkp_pkg::PRINT_HI))
                        begin
                            status.print_valid = 1'b1;
                            status.print_char  = prt_buffer_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        status.flag = prt_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prt_buffer_reg <= '0;
            prt_flag_reg   <= 1'b0;
            busy_count_reg <= '0;
        end
        else if (accept)
        begin
            prt_buffer_reg <= prt_buffer_next;
            prt_flag_reg   <= prt_flag_next;
            busy_count_reg <= busy_count_next;
        end
    end

endmodule

FILE: rtl/terminal_keyboard_printer_iface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_keyboard_printer_iface
// Terminal interface with a keyboard half and a printer half, one word in,
// one word out.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    in_data  (tkp_pkg::in_word_t)
//  output    out_valid / out_ready  out_data (tkp_pkg::out_word_t)
//  config    cfg_we                 cfg_index, cfg_wdata
//
//  Each accepted word is decoded and applied to the flag and buffer state in
//  the cycle it is accepted; its result appears in the output register in the
//  next cycle. One word per cycle is sustained while out_ready is high.
//  A stalled output word holds in_ready low until it is taken.
//  Reset clears both buffers, both flags and the print countdown, and loads
//  the configuration defaults.
// ----------------------------------------------------------------------------
module terminal_keyboard_printer_iface
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tkp_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tkp_pkg::out_word_t            out_data,
    input  logic                          cfg_we,
    input  logic [tkp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tkp_pkg::CFG_W-1:0]     cfg_wdata
);

    logic                        kbd_upper_reg;
    logic                        prt_upper_reg;
    logic [tkp_pkg::DELAY_W-1:0] delay_reg;
    logic                        out_valid_reg;
    tkp_pkg::out_word_t          out_word_reg, out_word_next;
    tkp_pkg::kbd_status_t        kbd_status;
    tkp_pkg::prt_status_t        prt_status;
    logic                        accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbd_upper_reg <= 1'b1;
            prt_upper_reg <= 1'b1;
            delay_reg     <= tkp_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tkp_pkg::cfg_idx_t'(cfg_index))
                tkp_pkg::CFG_KBD_UPPER: kbd_upper_reg <= cfg_wdata[0];
                tkp_pkg::CFG_PRT_UPPER: prt_upper_reg <= cfg_wdata[0];
                tkp_pkg::CFG_DELAY:     delay_reg     <= cfg_wdata[tkp_pkg::DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tkp_keyboard u_keyboard
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .word       (in_data),
        .upper_case (kbd_upper_reg),
        .status     (kbd_status)
    );

    tkp_printer u_printer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .word       (in_data),
        .upper_case (prt_upper_reg),
        .delay      (delay_reg),
        .status     (prt_status)
    );

    always_comb
    begin
        out_word_next.ac_out       = in_data.ac |
                                     tkp_pkg::AC_W'(kbd_status.ac_or);
        out_word_next.skip         = kbd_status.skip | prt_status.skip;
        out_word_next.print_valid  = prt_status.print_valid;
        out_word_next.print_char   = prt_status.print_char;
        out_word_next.kbd_flag_out = kbd_status.flag;
        out_word_next.prt_flag_out = prt_status.flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // A character is printed only on countdown expiry, which raises the flag.
    a_print_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.print_valid) |-> out_data.prt_flag_out)
        else $error("print without printer flag");

    a_idle_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.print_valid) |-> (out_data.print_char == '0))
        else $error("print_char nonzero without print_valid");

    a_nonpulse_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.command == tkp_pkg::CMD_KEY ||
                    in_data.command == tkp_pkg::CMD_TICK))
        |=> (out_valid && !out_data.skip && out_data.ac_out == $past(in_data.ac)))
        else $error("key or tick word altered ac or skip");

    a_key_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.command == tkp_pkg::CMD_KEY) |=> out_data.kbd_flag_out)
        else $error("key arrival did not raise keyboard flag");

endmodule

FILE: bench/terminal_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_scoreboard_pkg
// Status predictor and in-order checker for the terminal keyboard/printer
// interface. Each accepted input word is applied to a private copy of the
// flags, buffers, countdown and configuration, and the resulting status word
// is queued until the block returns its own.
// ----------------------------------------------------------------------------
package terminal_scoreboard_pkg;

    import tkp_pkg::*;

    class terminal_scoreboard;

        logic                 kbd_fold;
        logic                 prt_filter;
        logic [DELAY_W-1:0]   delay_ticks;

        logic [KEY_W-1:0]     key_buf;
        logic                 key_flag;
        logic [KEY_W-1:0]     char_buf;
        logic                 char_flag;
        logic [DELAY_W-1:0]   busy_ticks;

        out_word_t            pending_status[$];
        int unsigned          mismatches;

        function new();
            kbd_fold    = 1'b1;
            prt_filter  = 1'b1;
            delay_ticks = DELAY_RESET;
            key_buf     = '0;
            key_flag    = 1'b0;
            char_buf    = '0;
            char_flag   = 1'b0;
            busy_ticks  = '0;
            mismatches  = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_KBD_UPPER: kbd_fold    = value[0];
                CFG_PRT_UPPER: prt_filter  = value[0];
                CFG_DELAY:     delay_ticks = value[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function out_word_t step_terminal(in_word_t w);
            out_word_t         r;
            logic [CHAR_W-1:0] c;
            r             = '0;
            r.ac_out      = w.ac;
            case (w.command)
                CMD_KBD:
                begin
                    r.skip = w.pulse[PULSE_SKIP] && key_flag;
                    if (w.pulse[PULSE_CLEAR])
                    begin
                        key_flag = 1'b0;
                        r.ac_out = w.ac | {{(AC_W-KEY_W){1'b0}}, key_buf};
                    end
                end
                CMD_PRT:
                begin
                    r.skip = w.pulse[PULSE_SKIP] && char_flag;
                    if (w.pulse[PULSE_CLEAR])
                        char_flag = 1'b0;
                    if (w.pulse[PULSE_LOAD])
                    begin
                        // A load while busy only replaces the buffer.
                        if (busy_ticks == '0)
                            busy_ticks = (delay_ticks == '0) ? 16'd1 : delay_ticks;
                        char_buf = w.ac[KEY_W-1:0];
                    end
                end
                CMD_KEY:
                begin
                    c = w.key_code[CHAR_W-1:0];
                    if (kbd_fold && c >= LOWER_A && c <= LOWER_Z)
                        c = c - CASE_DIFF;
                    key_buf  = {1'b1, c};
                    key_flag = 1'b1;
                end
                default:
                begin
                    if (busy_ticks != '0)
                    begin
                        busy_ticks = busy_ticks - 16'd1;
                        if (busy_ticks == '0)
                        begin
                            c         = char_buf[CHAR_W-1:0];
                            char_flag = 1'b1;
                            if (!prt_filter || (c >= PRINT_LO && c <= PRINT_HI))
                            begin
                                r.print_valid = 1'b1;
                                r.print_char  = c;
                            end
                        end
                    end
                end
            endcase
            r.kbd_flag_out = key_flag;
            r.prt_flag_out = char_flag;
            return r;
        endfunction

        function void note_word(in_word_t w);
            pending_status.push_back(step_terminal(w));
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        task report_mismatch(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            $display("mismatch %0d at %0t: %s expected 'o%0o got 'o%0o",
                     mismatches, $realtime, what, want, got);
        endtask

        task check_word(out_word_t got);
            out_word_t want;
            if (pending_status.size() == 0)
            begin
                report_mismatch("unrequested word", 0, got);
                return;
            end
            want = pending_status.pop_front();
            if (got.ac_out !== want.ac_out)
                report_mismatch("ac_out", want.ac_out, got.ac_out);
            if (got.skip !== want.skip)
                report_mismatch("skip", want.skip, got.skip);
            if (got.print_valid !== want.print_valid)
                report_mismatch("print_valid", want.print_valid, got.print_valid);
            if (got.print_char !== want.print_char)
                report_mismatch("print_char", want.print_char, got.print_char);
            if (got.kbd_flag_out !== want.kbd_flag_out)
                report_mismatch("kbd_flag_out", want.kbd_flag_out, got.kbd_flag_out);
            if (got.prt_flag_out !== want.prt_flag_out)
                report_mismatch("prt_flag_out", want.prt_flag_out, got.prt_flag_out);
        endtask

    endclass

endpackage

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the terminal keyboard/printer interface with directed words, a long
// countdown and random phases under several settings and traffic patterns,
// checking every returned status word in order.
// ----------------------------------------------------------------------------
module testbench;

    import tkp_pkg::*;
    import terminal_scoreboard_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 140;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_word_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_word_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NONE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   quiet_cycles = 0;

    terminal_scoreboard   term_sb;

    terminal_keyboard_printer_iface i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            term_sb.note_word(in_data);
        if (rst_n && out_valid && out_ready)
            term_sb.check_word(out_data);
    end

    // Any accepted word in either direction counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_word_t make_word(cmd_t c, logic [2:0] p,
                                           logic [AC_W-1:0] a, logic [KEY_W-1:0] k);
        in_word_t w;
        w.command  = c;
        w.pulse    = p;
        w.ac       = a;
        w.key_code = k;
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       roll;
        roll       = $urandom_range(0, 99);
        w.pulse    = 3'($urandom_range(0, 7));
        w.ac       = AC_W'($urandom());
        w.key_code = KEY_W'($urandom());
        if (roll < 35)
            w.command = CMD_TICK;
        else if (roll < 60)
            w.command = CMD_PRT;
        else if (roll < 80)
            w.command = CMD_KBD;
        else
            w.command = CMD_KEY;
        // Lean on the lower-case range so folding is exercised often.
        if ($urandom_range(0, 99) < 40)
            w.key_code = {1'($urandom()), 7'($urandom_range(LOWER_A, LOWER_Z))};
        return w;
    endfunction

    task automatic drive_word(in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic set_traffic(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // The first edge lets the monitor note a word accepted at the last edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (term_sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Registers are only touched once the block has returned every word.
    task automatic reconfigure(logic kbd_upper, logic prt_upper, logic [DELAY_W-1:0] delay);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KBD_UPPER;
        cfg_wdata <= CFG_W'(kbd_upper);
        @(posedge clk);
        term_sb.set_register(CFG_KBD_UPPER, CFG_W'(kbd_upper));
        cfg_index <= CFG_PRT_UPPER;
        cfg_wdata <= CFG_W'(prt_upper);
        @(posedge clk);
        term_sb.set_register(CFG_PRT_UPPER, CFG_W'(prt_upper));
        cfg_index <= CFG_DELAY;
        cfg_wdata <= CFG_W'(delay);
        @(posedge clk);
        term_sb.set_register(CFG_DELAY, CFG_W'(delay));
        cfg_we    <= 1'b0;
        cfg_index <= CFG_NONE;
        @(posedge clk);
    endtask

    initial
    begin
        logic [DELAY_W-1:0] delay;

        term_sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. A delay of zero behaves like one tick.
        set_traffic(0);
        reconfigure(1'b1, 1'b1, 16'd0);
        drive_word(make_word(CMD_KBD,  3'o7, 18'o000000, 8'o000));
        drive_word(make_word(CMD_KEY,  3'o0, 18'o777777, 8'o141));
        drive_word(make_word(CMD_KBD,  3'o1, 18'o777777, 8'o377));
        drive_word(make_word(CMD_KBD,  3'o2, 18'o000000, 8'o000));
        drive_word(make_word(CMD_KEY,  3'o7, 18'o000000, 8'o377));
        drive_word(make_word(CMD_KEY,  3'o0, 18'o252525, 8'o172));
        drive_word(make_word(CMD_KBD,  3'o3, 18'o525252, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o1, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o777777, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o7, 18'o123456, 8'o377));
        drive_word(make_word(CMD_PRT,  3'o3, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o000101, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o000102, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o000006, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o6, 18'o000007, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o000137, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o7, 18'o000140, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));

        reconfigure(1'b0, 1'b0, 16'd1);
        drive_word(make_word(CMD_KEY,  3'o0, 18'o000000, 8'o141));
        drive_word(make_word(CMD_KBD,  3'o3, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o4, 18'o777777, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));

        // Long delay: the flag must stay low through every tick driven here, short of the last.
        reconfigure(1'b1, 1'b1, 16'd64);
        drive_word(make_word(CMD_PRT, 3'o4, 18'o000101, 8'o000));
        repeat (62)
            drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o1, 18'o000000, 8'o000));
        drive_word(make_word(CMD_TICK, 3'o0, 18'o000000, 8'o000));
        drive_word(make_word(CMD_PRT,  3'o3, 18'o000000, 8'o000));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                delay = 16'd1;
            else if (phase == RANDOM_PHASES - 1)
                delay = 16'd0;
            else
                delay = DELAY_W'($urandom_range(1, 12));
            reconfigure(1'($urandom()), 1'($urandom()), delay);
            set_traffic(phase % 4);
            repeat (PHASE_WORDS)
                drive_word(random_word());
        end

        drain();
        set_traffic(0);
        repeat (4) @(posedge clk);
        if (term_sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
